// ===== hw/rtl/rcbf_pkg.sv =====
package rcbf_pkg;

    // Default depth of the sample store
    localparam int STORE_DEPTH_DEF = 4096;

    // Field widths
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int RIDX_W  = 12;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = 13;
    localparam int RUN_W   = 15;
    localparam int CFGD_W  = 13;
    localparam int CFGI_W  = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

    // Register indexes
    localparam logic [CFGI_W-1:0] REG_RLE_ENABLE   = 1'b0;
    localparam logic [CFGI_W-1:0] REG_SAMPLE_LIMIT = 1'b1;

    // Reset values and fixed codes
    localparam logic [CNT_W-1:0]  LIMIT_RESET = 13'd100;
    localparam logic [WORD_W-1:0] FILL_WORD   = 16'h8282;
    localparam int                RUN_FLAG_BIT = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic fill;
        logic clear;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_go;
        logic fill_last;
        logic clear_last;
    } status_t;

endpackage

// ===== hw/rtl/rcbf_ctrl.sv =====
module rcbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rcbf_pkg::status_t status,
    output rcbf_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    rcbf_pkg::state_t state_reg;
    rcbf_pkg::state_t state_next;

    // State register; reset enters the store clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcbf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcbf_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = rcbf_pkg::ST_IDLE;
                end
            end
            rcbf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rcbf_pkg::ST_EXEC;
                end
            end
            rcbf_pkg::ST_EXEC:
            begin
                state_next = status.fill_go ? rcbf_pkg::ST_FILL : rcbf_pkg::ST_RESP;
            end
            rcbf_pkg::ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = rcbf_pkg::ST_RESP;
                end
            end
            rcbf_pkg::ST_RESP:
            begin
                state_next = start ? rcbf_pkg::ST_EXEC : rcbf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rcbf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy       = 1'b1;
        done       = 1'b0;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        cmd.fill   = 1'b0;
        cmd.clear  = 1'b0;
        unique case (state_reg)
            rcbf_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            rcbf_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            rcbf_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            rcbf_pkg::ST_FILL:
            begin
                cmd.fill = 1'b1;
            end
            rcbf_pkg::ST_RESP:
            begin
                busy       = 1'b0;
                done       = 1'b1;
                cmd.accept = start;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rcbf_datapath.sv =====
module rcbf_datapath #(
    parameter int STORE_DEPTH = rcbf_pkg::STORE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcbf_pkg::cmd_t              cmd,
    output rcbf_pkg::status_t           status,
    input  logic [rcbf_pkg::OP_W-1:0]   operation,
    input  logic [rcbf_pkg::BYTE_W-1:0] data_byte,
    input  logic [rcbf_pkg::RIDX_W-1:0] read_index,
    input  logic                        cfg_we,
    input  logic [rcbf_pkg::CFGI_W-1:0] cfg_index,
    input  logic [rcbf_pkg::CFGD_W-1:0] cfg_data,
    output logic [rcbf_pkg::WORD_W-1:0] read_data,
    output logic [rcbf_pkg::CNT_W-1:0]  samples_stored,
    output logic [rcbf_pkg::CNT_W-1:0]  window_start,
    output logic                        capture_full
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

    logic [rcbf_pkg::WORD_W-1:0] store_mem [STORE_DEPTH];

    // Configuration
    logic                        rle_enable_reg;
    logic [rcbf_pkg::CNT_W-1:0]  sample_limit_reg;

    // Latched beat
    logic [rcbf_pkg::OP_W-1:0]   op_reg;
    logic [rcbf_pkg::BYTE_W-1:0] byte_reg;
    logic [rcbf_pkg::RIDX_W-1:0] ridx_reg;

    // Capture state
    logic [rcbf_pkg::CNT_W-1:0]  count_reg,   count_next;
    logic [rcbf_pkg::BYTE_W-1:0] low_reg,     low_next;
    logic                        phase_reg,   phase_next;
    logic [rcbf_pkg::RUN_W-1:0]  pending_reg, pending_next;

    // Fill and clear sequencing
    logic [rcbf_pkg::CNT_W-1:0]  fill_addr_reg, fill_addr_next;
    logic [rcbf_pkg::CNT_W-1:0]  fill_left_reg, fill_left_next;
    logic [rcbf_pkg::WORD_W-1:0] word_reg,      word_next;
    logic [AW-1:0]               clear_addr_reg;

    // Read path
    logic [rcbf_pkg::WORD_W-1:0] rdata_reg;
    logic                        rd_en_reg;

    logic [rcbf_pkg::CNT_W-1:0]  lim;
    logic                        full;
    logic [rcbf_pkg::CNT_W-1:0]  room;
    logic [rcbf_pkg::WORD_W-1:0] word_in;
    logic                        run_cut;
    logic                        fill_go;
    logic [31:0]                 ridx_wide;
    logic [31:0]                 fill_wide;
    logic                        ridx_ok;

    // Effective limit: sample limit saturated to the store depth
    always_comb
    begin
        if (32'(sample_limit_reg) > 32'(STORE_DEPTH))
        begin
            lim = rcbf_pkg::CNT_W'(STORE_DEPTH);
        end
        else
        begin
            lim = sample_limit_reg;
        end
    end

    assign full      = (count_reg >= lim);
    assign room      = lim - count_reg;
    assign word_in   = {byte_reg, low_reg};
    assign run_cut   = ({1'b0, pending_reg} >= rcbf_pkg::WORD_W'(room));
    assign ridx_wide = 32'(ridx_reg);
    assign fill_wide = 32'(fill_addr_reg);
    assign ridx_ok   = (ridx_wide < 32'(STORE_DEPTH));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_enable_reg   <= 1'b0;
            sample_limit_reg <= rcbf_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rcbf_pkg::REG_RLE_ENABLE:   rle_enable_reg   <= cfg_data[0];
                rcbf_pkg::REG_SAMPLE_LIMIT: sample_limit_reg <= cfg_data;
                default:                    rle_enable_reg   <= rle_enable_reg;
            endcase
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= operation;
            byte_reg <= data_byte;
            ridx_reg <= read_index;
        end
    end

    // Decode the beat and work out the next capture state
    always_comb
    begin
        count_next     = count_reg;
        low_next       = low_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        fill_addr_next = fill_addr_reg;
        fill_left_next = fill_left_reg;
        word_next      = word_reg;
        fill_go        = 1'b0;
        if (cmd.exec)
        begin
            priority if (op_reg == rcbf_pkg::OP_DATA && !full)
            begin
                if (!phase_reg)
                begin
                    low_next   = byte_reg;
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    low_next   = '0;
                    if (rle_enable_reg && byte_reg[rcbf_pkg::RUN_FLAG_BIT])
                    begin
                        pending_next = word_in[rcbf_pkg::RUN_W-1:0];
                    end
                    else
                    begin
                        fill_go      = 1'b1;
                        word_next    = word_in;
                        pending_next = '0;
                        if (run_cut)
                        begin
                            fill_left_next = room - 1'b1;
                            count_next     = lim;
                        end
                        else
                        begin
                            fill_left_next = pending_reg[rcbf_pkg::CNT_W-1:0];
                            count_next     = count_reg + pending_reg[rcbf_pkg::CNT_W-1:0]
                                             + 1'b1;
                        end
                        fill_addr_next = lim - count_next;
                    end
                end
            end
            else if (op_reg == rcbf_pkg::OP_FRAME)
            begin
                count_next   = '0;
                phase_next   = 1'b0;
                low_next     = '0;
                pending_next = '0;
            end
            else
            begin
                count_next = count_reg;
            end
        end
        else if (cmd.fill)
        begin
            fill_addr_next = fill_addr_reg + 1'b1;
            fill_left_next = fill_left_reg - 1'b1;
        end
    end

    // Capture state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            low_reg     <= '0;
            phase_reg   <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            low_reg     <= low_next;
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

    // Fill run registers
    always_ff @(posedge clk)
    begin
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        word_reg      <= word_next;
    end

    // Advance the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            store_mem[clear_addr_reg] <= rcbf_pkg::FILL_WORD;
        end
        else if (cmd.fill)
        begin
            store_mem[fill_wide[AW-1:0]] <= word_reg;
        end
        if (cmd.exec)
        begin
            rdata_reg <= store_mem[ridx_wide[AW-1:0]];
        end
    end

    // Flag a read that returns store data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            rd_en_reg <= (op_reg == rcbf_pkg::OP_READ) && ridx_ok;
        end
    end

    assign status.fill_go    = fill_go;
    assign status.fill_last  = (fill_left_reg == '0);
    assign status.clear_last = (clear_addr_reg == LAST_ADDR);

    // Result fields
    assign read_data      = rd_en_reg ? rdata_reg : '0;
    assign samples_stored = count_reg;
    assign window_start   = full ? '0 : room;
    assign capture_full   = full;

endmodule

// ===== hw/rtl/rle_capture_buffer_filler.sv =====
// Channel  | Direction | Handshake             | Beat
// ---------+-----------+-----------------------+------------------------------------------
// command  | in        | start & !busy         | operation, data_byte, read_index
// result   | out       | done, one cycle       | read_data, samples_stored, window_start,
//          |           |                       | capture_full
// config   | in        | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// A command is decoded in the EXEC state and its result presented in the RESP state.
// A byte that completes a sample word adds a FILL state that writes it run count + 1
// times (once for a plain sample), one store write per cycle through the single store write port.
// After reset the store is cleared to 0x8282, one entry per cycle, and busy
// stays high until the clearing pass ends; config writes are taken throughout.
// done is high for exactly one cycle per command; the receiver cannot stall.
module rle_capture_buffer_filler #(
    parameter int STORE_DEPTH = rcbf_pkg::STORE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rcbf_pkg::OP_W-1:0]   operation,
    input  logic [rcbf_pkg::BYTE_W-1:0] data_byte,
    input  logic [rcbf_pkg::RIDX_W-1:0] read_index,
    output logic                        done,
    output logic [rcbf_pkg::WORD_W-1:0] read_data,
    output logic [rcbf_pkg::CNT_W-1:0]  samples_stored,
    output logic [rcbf_pkg::CNT_W-1:0]  window_start,
    output logic                        capture_full,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rcbf_pkg::CFGI_W-1:0] cfg_index,
    input  logic [rcbf_pkg::CFGD_W-1:0] cfg_data
);

    rcbf_pkg::cmd_t    cmd;
    rcbf_pkg::status_t status;

    // Config is always accepted
    assign cfg_ready = 1'b1;

    rcbf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rcbf_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .data_byte      (data_byte),
        .read_index     (read_index),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .read_data      (read_data),
        .samples_stored (samples_stored),
        .window_start   (window_start),
        .capture_full   (capture_full)
    );

endmodule

// ===== tb/tb_rle_capture_buffer_filler.sv =====
module tb_rle_capture_buffer_filler;

    localparam int STORE_DEPTH    = rcbf_pkg::STORE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 30000;

    // Operation code the block leaves unused
    localparam logic [rcbf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [rcbf_pkg::WORD_W-1:0] read_data;
        logic [rcbf_pkg::CNT_W-1:0]  samples_stored;
        logic [rcbf_pkg::CNT_W-1:0]  window_start;
        logic                        capture_full;
    } capture_beat_t;

    // Tracks the capture state and the result beats still owed by the block
    class capture_tracker;
        logic [rcbf_pkg::WORD_W-1:0] sample_mem [STORE_DEPTH];
        int unsigned                 count;
        logic [rcbf_pkg::BYTE_W-1:0] low_byte;
        bit                          high_next;
        logic [rcbf_pkg::RUN_W-1:0]  run_pending;
        bit                          rle_on;
        int unsigned                 limit_reg;
        capture_beat_t               due_beats [$];
        int unsigned                 errors;

        function new();
            foreach (sample_mem[i])
                sample_mem[i] = rcbf_pkg::FILL_WORD;
            count       = 0;
            low_byte    = '0;
            high_next   = 1'b0;
            run_pending = '0;
            rle_on      = 1'b0;
            limit_reg   = rcbf_pkg::LIMIT_RESET;
            errors      = 0;
        endfunction

        function int unsigned eff_limit();
            return (limit_reg > STORE_DEPTH) ? STORE_DEPTH : limit_reg;
        endfunction

        function void configure(logic [rcbf_pkg::CFGI_W-1:0] idx,
                                logic [rcbf_pkg::CFGD_W-1:0] value);
            if (idx == rcbf_pkg::REG_RLE_ENABLE)
                rle_on = value[0];
            else
                limit_reg = value;
        endfunction

        // Apply one accepted command and queue the beat it must produce
        function void note_command(logic [rcbf_pkg::OP_W-1:0] op,
                                   logic [rcbf_pkg::BYTE_W-1:0] b,
                                   logic [rcbf_pkg::RIDX_W-1:0] ridx);
            int unsigned   lim;
            int unsigned   total;
            int unsigned   run;
            int unsigned   base_idx;
            logic [15:0]   word;
            capture_beat_t beat;
            lim = eff_limit();
            beat.read_data = '0;
            case (op)
                rcbf_pkg::OP_DATA:
                begin
                    if (count < lim)
                    begin
                        if (!high_next)
                        begin
                            low_byte  = b;
                            high_next = 1'b1;
                        end
                        else
                        begin
                            high_next = 1'b0;
                            word      = {b, low_byte};
                            low_byte  = '0;
                            if (rle_on && b[rcbf_pkg::RUN_FLAG_BIT])
                                run_pending = word[rcbf_pkg::RUN_W-1:0];
                            else
                            begin
                                // expand the run, cut at the limit, fill downwards
                                run   = run_pending;
                                total = count + run + 1;
                                if (total > lim)
                                begin
                                    run   = run - (total - lim);
                                    total = lim;
                                end
                                count    = total;
                                base_idx = lim - total;
                                for (int unsigned i = 0; i <= run; i++)
                                    if (base_idx + i < STORE_DEPTH)
                                        sample_mem[base_idx + i] = word;
                                run_pending = '0;
                            end
                        end
                    end
                end
                rcbf_pkg::OP_READ:
                begin
                    if (ridx < STORE_DEPTH)
                        beat.read_data = sample_mem[ridx];
                end
                rcbf_pkg::OP_FRAME:
                begin
                    count       = 0;
                    high_next   = 1'b0;
                    low_byte    = '0;
                    run_pending = '0;
                end
                default:
                begin
                end
            endcase
            beat.samples_stored = rcbf_pkg::CNT_W'(count);
            beat.window_start   = (count >= lim) ? '0 : rcbf_pkg::CNT_W'(lim - count);
            beat.capture_full   = (count >= lim);
            due_beats.push_back(beat);
        endfunction

        // Compare one result beat against the oldest one owed
        function void check_beat(capture_beat_t got);
            capture_beat_t want;
            if (due_beats.size() == 0)
            begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
                errors++;
            end
            if (got.samples_stored !== want.samples_stored)
            begin
                $error("samples_stored: expected %0d, actual %0d",
                       want.samples_stored, got.samples_stored);
                errors++;
            end
            if (got.window_start !== want.window_start)
            begin
                $error("window_start: expected %0d, actual %0d",
                       want.window_start, got.window_start);
                errors++;
            end
            if (got.capture_full !== want.capture_full)
            begin
                $error("capture_full: expected %b, actual %b",
                       want.capture_full, got.capture_full);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [rcbf_pkg::OP_W-1:0]     operation = rcbf_pkg::OP_DATA;
    logic [rcbf_pkg::BYTE_W-1:0]   data_byte = '0;
    logic [rcbf_pkg::RIDX_W-1:0]   read_index = '0;
    logic                          done;
    logic [rcbf_pkg::WORD_W-1:0]   read_data;
    logic [rcbf_pkg::CNT_W-1:0]    samples_stored;
    logic [rcbf_pkg::CNT_W-1:0]    window_start;
    logic                          capture_full;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rcbf_pkg::CFGI_W-1:0]   cfg_index = rcbf_pkg::REG_RLE_ENABLE;
    logic [rcbf_pkg::CFGD_W-1:0]   cfg_data = '0;

    capture_tracker tracker = new();
    int             idle_pct = 0;
    int             stall_cycles = 0;

    rle_capture_buffer_filler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .data_byte      (data_byte),
        .read_index     (read_index),
        .done           (done),
        .read_data      (read_data),
        .samples_stored (samples_stored),
        .window_start   (window_start),
        .capture_full   (capture_full),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    // Check every result beat at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_beat(capture_beat_t'{read_data, samples_stored,
                                               window_start, capture_full});
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb_rle_capture_buffer_filler: errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Issue one command; start stays high so the next one can follow at once
    task automatic send_cmd(input logic [rcbf_pkg::OP_W-1:0] op,
                            input logic [rcbf_pkg::BYTE_W-1:0] b,
                            input logic [rcbf_pkg::RIDX_W-1:0] ridx);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        data_byte  <= b;
        read_index <= ridx;
        do
            @(posedge clk);
        while (busy);
        tracker.note_command(op, b, ridx);
    endtask

    // Send a data byte, counting it only if the block will act on it
    task automatic send_byte(input logic [rcbf_pkg::BYTE_W-1:0] b, inout int taken);
        if (tracker.count < tracker.eff_limit())
            taken++;
        send_cmd(rcbf_pkg::OP_DATA, b, rcbf_pkg::RIDX_W'($urandom));
    endtask

    // Drain outstanding results, then write both registers
    task automatic set_config(input bit rle, input logic [rcbf_pkg::CFGD_W-1:0] lim);
        start <= 1'b0;
        @(negedge clk);
        while (tracker.due_beats.size() != 0)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= rcbf_pkg::REG_RLE_ENABLE;
        cfg_data  <= rcbf_pkg::CFGD_W'(rle);
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.configure(rcbf_pkg::REG_RLE_ENABLE, rcbf_pkg::CFGD_W'(rle));
        cfg_index <= rcbf_pkg::REG_SAMPLE_LIMIT;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.configure(rcbf_pkg::REG_SAMPLE_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed word streams, with reads, frames and stray bytes mixed in
    task automatic random_phase(input bit rle, input logic [rcbf_pkg::CFGD_W-1:0] lim_cfg,
                                input int idle, input int n_items);
        int                          taken;
        int                          pick;
        int unsigned                 lim;
        int unsigned                 lo;
        logic [rcbf_pkg::WORD_W-1:0] word;
        logic [rcbf_pkg::RUN_W-1:0]  run;
        set_config(rle, lim_cfg);
        idle_pct = idle;
        taken = 0;
        while (taken < n_items)
        begin
            pick = $urandom_range(99);
            lim  = tracker.eff_limit();
            if (tracker.count >= lim && pick < 50)
            begin
                send_cmd(rcbf_pkg::OP_FRAME, rcbf_pkg::BYTE_W'($urandom),
                         rcbf_pkg::RIDX_W'($urandom));
                taken++;
            end
            else if (pick < 14)
            begin
                // read mostly inside the filled window
                if (lim != 0 && tracker.count != 0 && pick < 10)
                begin
                    lo = (tracker.count >= lim) ? 0 : lim - tracker.count;
                    send_cmd(rcbf_pkg::OP_READ, rcbf_pkg::BYTE_W'($urandom),
                             rcbf_pkg::RIDX_W'($urandom_range(lim - 1, lo)));
                end
                else
                    send_cmd(rcbf_pkg::OP_READ, rcbf_pkg::BYTE_W'($urandom),
                             rcbf_pkg::RIDX_W'($urandom));
                taken++;
            end
            else if (pick < 17)
            begin
                send_cmd(rcbf_pkg::OP_FRAME, rcbf_pkg::BYTE_W'($urandom),
                         rcbf_pkg::RIDX_W'($urandom));
                taken++;
            end
            else if (pick < 19)
            begin
                send_cmd(OP_UNUSED, rcbf_pkg::BYTE_W'($urandom), rcbf_pkg::RIDX_W'($urandom));
                taken++;
            end
            else if (pick < 23)
                send_byte(rcbf_pkg::BYTE_W'($urandom), taken);
            else
            begin
                // build a run word or a sample word, low byte first
                if (tracker.rle_on && $urandom_range(3) == 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < 75)
                        run = rcbf_pkg::RUN_W'($urandom_range(7));
                    else if (pick < 95)
                        run = rcbf_pkg::RUN_W'($urandom_range(255));
                    else
                        run = rcbf_pkg::RUN_W'($urandom);
                    word = {1'b1, run};
                end
                else if (tracker.rle_on)
                    word = {1'b0, rcbf_pkg::RUN_W'($urandom)};
                else
                    word = rcbf_pkg::WORD_W'($urandom);
                send_byte(word[7:0], taken);
                send_byte(word[15:8], taken);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: runs, replaced run, fill up to the limit, ignored bytes, reads
        set_config(1'b1, 13'd5);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'h000);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'hFFF);
        send_cmd(OP_UNUSED, 8'hFF, 12'hFFF);
        send_cmd(rcbf_pkg::OP_DATA, 8'h34, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h12, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h02, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h80, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h03, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h80, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h00, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h7F, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'hAA, 12'h000);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'h000);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'h004);
        send_cmd(rcbf_pkg::OP_FRAME, 8'h00, 12'h000);

        // Zero limit: full at once
        set_config(1'b0, 13'd0);
        send_cmd(rcbf_pkg::OP_DATA, 8'h55, 12'h000);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'h000);

        // Oversized limit, then a run count carried over into RLE-off mode
        set_config(1'b1, 13'h1FFF);
        send_cmd(rcbf_pkg::OP_DATA, 8'h05, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h80, 12'h000);
        set_config(1'b0, 13'h1FFF);
        send_cmd(rcbf_pkg::OP_DATA, 8'h11, 12'h000);
        send_cmd(rcbf_pkg::OP_DATA, 8'h91, 12'h000);

        // Limit lowered below the count
        set_config(1'b0, 13'd3);
        send_cmd(rcbf_pkg::OP_DATA, 8'h00, 12'h000);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'hFFF);
        send_cmd(rcbf_pkg::OP_FRAME, 8'h00, 12'h000);
        send_cmd(rcbf_pkg::OP_READ, 8'h00, 12'h001);

        // Random phases across settings and idling patterns
        random_phase(1'b1, 13'd64, 0, 260);
        random_phase(1'b1, 13'd4096, 60, 260);
        random_phase(1'b0, 13'h1FFF, 11, 250);
        random_phase(1'b1, 13'd1, 0, 200);
        random_phase(1'b0, 13'd200, 60, 260);
        random_phase(1'b1, 13'd0, 11, 60);
        random_phase(1'b1, 13'd300, 60, 260);
        random_phase(1'b1, 13'd16, 0, 250);
        random_phase(1'b0, 13'd37, 11, 200);

        // Drain, let the block settle, report
        start <= 1'b0;
        @(negedge clk);
        while (tracker.due_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb_rle_capture_buffer_filler: clean");
        else
            $display("tb_rle_capture_buffer_filler: errors");
        $finish;
    end

endmodule
